### sv/ffea_pkg.sv
// ============================================================================
// ffea_pkg
// Shared types and constants of the first-fit entry allocator.
// ============================================================================
`default_nettype none

package ffea_pkg;

    localparam int COUNT_W  = 11;
    localparam int INDEX_W  = 10;
    localparam int CFG_W    = 11;
    localparam int STATUS_W = 3;
    localparam int MARK_W   = 3;

    localparam logic [CFG_W-1:0] ENTRIES_RESET = 11'd1024;

    typedef logic [MARK_W-1:0] mark_t;

    // bit 0 used, bit 1 first, bit 2 last
    localparam mark_t MARK_FREE  = 3'b000;
    localparam mark_t MARK_USED  = 3'b001;
    localparam mark_t MARK_FIRST = 3'b011;
    localparam mark_t MARK_LAST  = 3'b101;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK           = 3'd0,
        ST_ZERO_COUNT   = 3'd1,
        ST_NO_ROOM      = 3'd2,
        ST_OUT_OF_RANGE = 3'd3,
        ST_NOT_FIRST    = 3'd4,
        ST_FREE_IN_RUN  = 3'd5
    } status_t;

    typedef enum logic [2:0]
    {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_WALK,
        S_FINISH
    } seq_state_t;

    typedef struct packed
    {
        logic  rd_en;
        logic  wr_en;
        mark_t wr_mark;
    } mem_ctl_t;

    typedef struct packed
    {
        logic                 valid;
        status_t              status;
        logic [INDEX_W-1:0]   run_start;
    } result_t;

endpackage

`default_nettype wire

### sv/ffea_mark_ram.sv
// ============================================================================
// ffea_mark_ram
// Entry mark table: one write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module ffea_mark_ram #(
    parameter int TABLE_DEPTH = 1024,
    parameter int AW          = 10
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire ffea_pkg::mark_t      wr_data,
    input  wire logic                 rd_en,
    input  wire logic [AW-1:0]        rd_addr,
    output      ffea_pkg::mark_t      rd_data
);

    ffea_pkg::mark_t mem [TABLE_DEPTH];
    ffea_pkg::mark_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### sv/ffea_seq.sv
// ============================================================================
// ffea_seq
// Sequencer: clearing pass, first-fit scan, run marking and run freeing walk.
// ============================================================================
`default_nettype none

module ffea_seq #(
    parameter int TABLE_DEPTH = 1024,
    parameter int AW          = 10,
    parameter int NW          = 11
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output      logic                              in_stall,
    input  wire ffea_pkg::opcode_t                 opcode,
    input  wire logic [ffea_pkg::COUNT_W-1:0]      entry_count,
    input  wire logic [ffea_pkg::INDEX_W-1:0]      start_index,
    input  wire logic [NW-1:0]                     managed,
    input  wire logic                              res_ready,
    output      ffea_pkg::result_t                 res,
    output      ffea_pkg::mem_ctl_t                mem_ctl,
    output      logic [AW-1:0]                     wr_addr,
    output      logic [AW-1:0]                     rd_addr,
    input  wire ffea_pkg::mark_t                   rd_data
);

    ffea_pkg::seq_state_t state_reg, state_next;
    logic [NW-1:0]        idx_reg, idx_next;
    logic [NW-1:0]        run_reg, run_next;
    logic [NW-1:0]        count_reg, count_next;
    logic [NW-1:0]        start_reg, start_next;
    logic [NW-1:0]        last_reg, last_next;
    logic                 first_reg, first_next;
    ffea_pkg::status_t    status_reg, status_next;

    logic [NW-1:0]        run_inc;
    logic [NW-1:0]        idx_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ffea_pkg::S_CLEAR;
            idx_reg    <= '0;
            run_reg    <= '0;
            count_reg  <= '0;
            start_reg  <= '0;
            last_reg   <= '0;
            first_reg  <= 1'b0;
            status_reg <= ffea_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            run_reg    <= run_next;
            count_reg  <= count_next;
            start_reg  <= start_next;
            last_reg   <= last_next;
            first_reg  <= first_next;
            status_reg <= status_next;
        end
    end

    assign idx_in = NW'(start_index);

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        run_next    = run_reg;
        count_next  = count_reg;
        start_next  = start_reg;
        last_next   = last_reg;
        first_next  = first_reg;
        status_next = status_reg;
        in_stall    = 1'b1;
        mem_ctl     = '0;
        run_inc     = (rd_data == ffea_pkg::MARK_FREE) ? run_reg + NW'(1) : '0;
        res.valid     = 1'b0;
        res.status    = status_reg;
        res.run_start = ffea_pkg::INDEX_W'(start_reg);

        unique case (state_reg)
            ffea_pkg::S_CLEAR:
            begin
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.wr_mark = ffea_pkg::MARK_FREE;
                idx_next        = idx_reg + NW'(1);
                if (idx_reg == NW'(TABLE_DEPTH - 1))
                begin
                    idx_next   = '0;
                    state_next = ffea_pkg::S_IDLE;
                end
            end

            ffea_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    start_next  = '0;
                    first_next  = 1'b1;
                    run_next    = '0;
                    status_next = ffea_pkg::ST_OK;
                    count_next  = NW'(entry_count);
                    if (opcode == ffea_pkg::OP_ALLOC)
                    begin
                        if (entry_count == '0)
                        begin
                            status_next = ffea_pkg::ST_ZERO_COUNT;
                            state_next  = ffea_pkg::S_FINISH;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = ffea_pkg::S_SCAN;
                        end
                    end
                    else
                    begin
                        if (idx_in >= managed)
                        begin
                            status_next = ffea_pkg::ST_OUT_OF_RANGE;
                            state_next  = ffea_pkg::S_FINISH;
                        end
                        else
                        begin
                            idx_next   = idx_in;
                            state_next = ffea_pkg::S_WALK;
                        end
                    end
                end
            end

            // rd_data holds the mark of entry idx_reg
            ffea_pkg::S_SCAN:
            begin
                if (idx_reg >= managed)
                begin
                    status_next = ffea_pkg::ST_NO_ROOM;
                    state_next  = ffea_pkg::S_FINISH;
                end
                else if (run_inc == count_reg)
                begin
                    start_next = idx_reg + NW'(1) - count_reg;
                    last_next  = idx_reg;
                    idx_next   = idx_reg + NW'(1) - count_reg;
                    state_next = ffea_pkg::S_MARK;
                end
                else
                begin
                    run_next = run_inc;
                    idx_next = idx_reg + NW'(1);
                end
            end

            ffea_pkg::S_MARK:
            begin
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.wr_mark = ffea_pkg::MARK_USED;
                if (idx_reg == start_reg)
                begin
                    mem_ctl.wr_mark = mem_ctl.wr_mark | ffea_pkg::MARK_FIRST;
                end
                if (idx_reg == last_reg)
                begin
                    mem_ctl.wr_mark = mem_ctl.wr_mark | ffea_pkg::MARK_LAST;
                    state_next      = ffea_pkg::S_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + NW'(1);
                end
            end

            ffea_pkg::S_WALK:
            begin
                first_next = 1'b0;
                if (first_reg && ((rd_data & ffea_pkg::MARK_FIRST) != ffea_pkg::MARK_FIRST))
                begin
                    status_next = ffea_pkg::ST_NOT_FIRST;
                    state_next  = ffea_pkg::S_FINISH;
                end
                else if (idx_reg >= managed)
                begin
                    // walked off the managed end without a last mark
                    state_next = ffea_pkg::S_FINISH;
                end
                else
                begin
                    mem_ctl.wr_en   = 1'b1;
                    mem_ctl.wr_mark = ffea_pkg::MARK_FREE;
                    if ((rd_data & ffea_pkg::MARK_LAST) == ffea_pkg::MARK_LAST)
                    begin
                        state_next = ffea_pkg::S_FINISH;
                    end
                    else
                    begin
                        if (!rd_data[0])
                        begin
                            status_next = ffea_pkg::ST_FREE_IN_RUN;
                        end
                        idx_next = idx_reg + NW'(1);
                    end
                end
            end

            ffea_pkg::S_FINISH:
            begin
                if (res_ready)
                begin
                    res.valid  = 1'b1;
                    state_next = ffea_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ffea_pkg::S_IDLE;
            end
        endcase

        mem_ctl.rd_en = (state_next == ffea_pkg::S_SCAN) || (state_next == ffea_pkg::S_WALK);
    end

    assign wr_addr = idx_reg[AW-1:0];
    assign rd_addr = idx_next[AW-1:0];

endmodule

`default_nettype wire

### sv/first_fit_entry_allocator.sv
// ============================================================================
// first_fit_entry_allocator
// First-fit allocator of contiguous runs of entries in a mark table.
// ============================================================================
//
// Input channel (in_valid / in_stall) takes one request beat: opcode selects
// allocate (entry_count entries) or free (run starting at start_index).
// Output channel (out_valid / out_stall) returns one beat per request with
// status and run_start. cfg_wr_en / cfg_wr_data set the managed entry
// count; the user must write it only while no request is in flight, and
// the block itself does not enforce this. An allocate scans the entries
// from zero until a free run of entry_count fits, then marks that run;
// with no room it scans all managed entries. A free walks the run from
// start_index, clearing entries through the last mark; a free not at a run
// start stops at its first entry; errors found at accept finish without
// touching the table. The single mark port pair takes one entry per cycle.
// One request is in work at a time; the next is accepted the cycle after
// the previous result enters the output register.
// After reset a clearing pass writes every entry free with in_stall high;
// config writes are taken meanwhile.
// A finished beat sits in the output register while out_stall is high; the
// next request is accepted meanwhile and its result waits behind it.
// ============================================================================
`default_nettype none

module first_fit_entry_allocator #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [ffea_pkg::CFG_W-1:0]        cfg_wr_data,
    input  wire logic                              in_valid,
    output      logic                              in_stall,
    input  wire logic                              opcode,
    input  wire logic [ffea_pkg::COUNT_W-1:0]      entry_count,
    input  wire logic [ffea_pkg::INDEX_W-1:0]      start_index,
    output      logic                              out_valid,
    input  wire logic                              out_stall,
    output      logic [ffea_pkg::STATUS_W-1:0]     status,
    output      logic [ffea_pkg::INDEX_W-1:0]      run_start
);

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int IW_RAW = $clog2(TABLE_DEPTH + 1);
    localparam int NW     = (IW_RAW > ffea_pkg::CFG_W) ? IW_RAW : ffea_pkg::CFG_W;

    logic [ffea_pkg::CFG_W-1:0]  entries_in_use_reg;
    logic [NW-1:0]               eiu_ext;
    logic [NW-1:0]               managed;

    logic                        out_valid_reg;
    ffea_pkg::status_t           status_reg;
    logic [ffea_pkg::INDEX_W-1:0] run_start_reg;

    logic                        res_ready;
    ffea_pkg::result_t           res;
    ffea_pkg::mem_ctl_t          mem_ctl;
    logic [AW-1:0]               wr_addr;
    logic [AW-1:0]               rd_addr;
    ffea_pkg::mark_t             rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= ffea_pkg::ENTRIES_RESET;
        end
        else if (cfg_wr_en)
        begin
            entries_in_use_reg <= cfg_wr_data;
        end
    end

    assign eiu_ext = NW'(entries_in_use_reg);
    assign managed = (eiu_ext > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : eiu_ext;

    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            status_reg    <= res.status;
            run_start_reg <= res.run_start;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign run_start = run_start_reg;

    ffea_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW),
        .NW          (NW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (ffea_pkg::opcode_t'(opcode)),
        .entry_count (entry_count),
        .start_index (start_index),
        .managed     (managed),
        .res_ready   (res_ready),
        .res         (res),
        .mem_ctl     (mem_ctl),
        .wr_addr     (wr_addr),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    ffea_mark_ram #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_ctl.wr_en),
        .wr_addr (wr_addr),
        .wr_data (mem_ctl.wr_mark),
        .rd_en   (mem_ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

### sv/ffea_checker.sv
// ============================================================================
// ffea_checker
// Port-level checks of the first-fit entry allocator, bound to the top level.
// ============================================================================
`default_nettype none

module ffea_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_stall,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire logic [ffea_pkg::STATUS_W-1:0]     status,
    input  wire logic [ffea_pkg::INDEX_W-1:0]      run_start
);

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(run_start))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ffea_pkg::STATUS_W'(ffea_pkg::ST_FREE_IN_RUN))
        else $error("status code out of range");

    // failed requests report start zero
    a_fail_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ffea_pkg::STATUS_W'(ffea_pkg::ST_OK) |-> run_start == '0)
        else $error("nonzero run_start on failure");

    // one request in work at a time
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request accepted back to back");

endmodule

bind first_fit_entry_allocator ffea_checker u_ffea_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .run_start (run_start)
);

`default_nettype wire
